@@ src/sit_pkg.sv @@
// Shared constants, types and helpers of the segment intersection test unit.
package sit_pkg;

  localparam int CW = 16;
  localparam int IN_W = 16;
  localparam int FRAC = 16;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;
  localparam int NW = DW + SW + 2;
  localparam int DENW = SW;
  localparam int QW = 32;
  localparam int HIW = NW + FRAC - QW;
  localparam int DIV_STEP = 2;
  localparam int DIV_STG = QW / DIV_STEP;
  localparam int DIV_LAT = DIV_STG + 2;
  localparam int GEOM_LAT = 5;
  localparam int LAT = GEOM_LAT + DIV_LAT;
  localparam int NCRD = 8;
  localparam int OUT_W = 72;

  typedef logic signed [CW-1:0] crd_t;

  typedef struct packed {
    logic                   hit;
    logic                   par;
    logic signed [NW-1:0]   nx;
    logic signed [NW-1:0]   ny;
    logic signed [SW-1:0]   det;
  } geom_out_t;

  typedef struct packed {
    logic [QW-1:0] q;
    logic          ovf;
    logic          neg;
  } div_res_t;

  typedef struct packed {
    logic hit;
    logic par;
  } side_t;

  function automatic logic signed [DW-1:0] sx(input logic signed [CW-1:0] v);
    return DW'(v);
  endfunction

endpackage

@@ src/segment_intersection_test_unit.sv @@
// Top level of the segment intersection test unit with APB registers and stream ports.
// Throughput: one item per cycle; the whole pipeline advances whenever the output
// register is empty or its item is taken, so stalls hold every stage in place.
// Reset clears the valid bits, the output register valid and both tolerance registers.
module segment_intersection_test_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // ax0, ay0, ax1, ay1, bx0, by0, bx1, by1 (16 bits each) from bit 0 up.
  input  logic [127:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // intersects, lines_parallel, point_x (32), point_y (32), point_saturated, zero fill.
  output logic [71:0]   m_axis_tdata
);

  localparam int QW = sit_pkg::QW;
  localparam int LAT = sit_pkg::LAT;
  localparam int DLAT = sit_pkg::DIV_LAT;

  logic [7:0]  coord_tol_q;
  logic [15:0] cross_tol_q;
  logic        wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign prdata = paddr[2] ? {16'd0, cross_tol_q} : {24'd0, coord_tol_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coord_tol_q <= '0;
      cross_tol_q <= '0;
    end else if (wr) begin
      if (paddr[2]) begin
        cross_tol_q <= pwdata[15:0];
      end else begin
        coord_tol_q <= pwdata[7:0];
      end
    end
  end

  logic en;
  logic out_vld_q;

  assign en = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = out_vld_q;

  sit_pkg::crd_t crd [sit_pkg::NCRD];

  always_comb begin
    for (int i = 0; i < sit_pkg::NCRD; i++) begin
      crd[i] = s_axis_tdata[i*sit_pkg::IN_W +: sit_pkg::CW];
    end
  end

  sit_pkg::geom_out_t geo;
  sit_pkg::div_res_t  rx, ry;

  sit_geom u_geom (
    .clk_i       (clk_i),
    .en_i        (en),
    .crd_i       (crd),
    .coord_tol_i (coord_tol_q),
    .cross_tol_i (cross_tol_q),
    .out_o       (geo)
  );

  sit_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (geo.nx),
    .den_i (geo.det),
    .res_o (rx)
  );

  sit_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (geo.ny),
    .den_i (geo.det),
    .res_o (ry)
  );

  logic          vld_q  [LAT];
  sit_pkg::side_t side_q [DLAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) begin
        vld_q[i] <= 1'b0;
      end
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= s_axis_tvalid;
      for (int i = 1; i < LAT; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
      out_vld_q <= vld_q[LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0].hit <= geo.hit;
      side_q[0].par <= geo.par;
      for (int i = 1; i < DLAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  function automatic logic [QW:0] fix_out(input sit_pkg::div_res_t r);
    logic [QW-1:0] lim;
    logic [QW-1:0] v;
    logic          s;
    lim = r.neg ? {1'b1, (QW-1)'(0)} : {1'b0, {(QW-1){1'b1}}};
    s   = r.ovf || (r.q > lim);
    v   = s ? lim : r.q;
    return {s, (r.neg ? QW'(-v) : v)};
  endfunction

  logic [QW:0] fx, fy;
  logic [QW-1:0] px_q, py_q;
  logic hit_q, par_q, sat_q;

  assign fx = fix_out(rx);
  assign fy = fix_out(ry);

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= side_q[DLAT-1].hit;
      par_q <= side_q[DLAT-1].par;
      if (side_q[DLAT-1].par) begin
        px_q  <= '0;
        py_q  <= '0;
        sat_q <= 1'b0;
      end else begin
        px_q  <= fx[QW-1:0];
        py_q  <= fy[QW-1:0];
        sat_q <= fx[QW] || fy[QW];
      end
    end
  end

  assign m_axis_tdata = {5'd0, sat_q, py_q, px_q, par_q, hit_q};

endmodule

@@ src/sit_geom.sv @@
// Geometry pipeline: interval overlap, orientation tests, determinant and numerators.
module sit_geom (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  sit_pkg::crd_t             crd_i [sit_pkg::NCRD],
  input  logic [7:0]                coord_tol_i,
  input  logic [15:0]               cross_tol_i,
  output sit_pkg::geom_out_t        out_o
);

  localparam int DW = sit_pkg::DW;
  localparam int PW = sit_pkg::PW;
  localparam int SW = sit_pkg::SW;
  localparam int NW = sit_pkg::NW;

  // Stage A
  logic signed [DW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  logic signed [DW-1:0] lox1, hix1, lox2, hix2, loy1, hiy1, loy2, hiy2, tol;
  logic signed [DW-1:0] dif_d [12];
  logic signed [DW-1:0] dif_q [12];
  logic signed [DW-1:0] crd_d [4];
  logic signed [DW-1:0] crd_q [4];
  logic ov_d, ov_a_q;

  always_comb begin
    ax0 = sit_pkg::sx(crd_i[0]);
    ay0 = sit_pkg::sx(crd_i[1]);
    ax1 = sit_pkg::sx(crd_i[2]);
    ay1 = sit_pkg::sx(crd_i[3]);
    bx0 = sit_pkg::sx(crd_i[4]);
    by0 = sit_pkg::sx(crd_i[5]);
    bx1 = sit_pkg::sx(crd_i[6]);
    by1 = sit_pkg::sx(crd_i[7]);
    tol = DW'($signed({1'b0, coord_tol_i}));
    lox1 = (ax0 < ax1) ? ax0 : ax1;
    hix1 = (ax0 < ax1) ? ax1 : ax0;
    lox2 = (bx0 < bx1) ? bx0 : bx1;
    hix2 = (bx0 < bx1) ? bx1 : bx0;
    loy1 = (ay0 < ay1) ? ay0 : ay1;
    hiy1 = (ay0 < ay1) ? ay1 : ay0;
    loy2 = (by0 < by1) ? by0 : by1;
    hiy2 = (by0 < by1) ? by1 : by0;
    ov_d = (((lox1 > lox2) ? lox1 : lox2) <= (((hix1 < hix2) ? hix1 : hix2) + tol)) &&
           (((loy1 > loy2) ? loy1 : loy2) <= (((hiy1 < hiy2) ? hiy1 : hiy2) + tol));
    dif_d[0]  = ax1 - ax0;
    dif_d[1]  = ay1 - ay0;
    dif_d[2]  = bx1 - bx0;
    dif_d[3]  = by1 - by0;
    dif_d[4]  = bx0 - ax0;
    dif_d[5]  = by0 - ay0;
    dif_d[6]  = bx1 - ax0;
    dif_d[7]  = by1 - ay0;
    dif_d[8]  = ax1 - bx0;
    dif_d[9]  = ay1 - by0;
    dif_d[10] = ay0 - ay1;
    dif_d[11] = by0 - by1;
    crd_d[0] = ax0;
    crd_d[1] = ay0;
    crd_d[2] = bx0;
    crd_d[3] = by0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dif_q  <= dif_d;
      crd_q  <= crd_d;
      ov_a_q <= ov_d;
    end
  end

  // Stage B: b1 = dif[0], hya = dif[1], b2 = dif[2], gby = dif[3], a1 = dif[10], a2 = dif[11].
  logic signed [DW-1:0] opa [14];
  logic signed [DW-1:0] opb [14];
  logic signed [PW-1:0] prd_q [14];
  logic signed [DW-1:0] ab_b_q [4];
  logic ov_b_q;

  always_comb begin
    opa[0]  = dif_q[0];  opb[0]  = dif_q[5];
    opa[1]  = dif_q[1];  opb[1]  = dif_q[4];
    opa[2]  = dif_q[0];  opb[2]  = dif_q[7];
    opa[3]  = dif_q[1];  opb[3]  = dif_q[6];
    opa[4]  = dif_q[3];  opb[4]  = dif_q[4];
    opa[5]  = dif_q[2];  opb[5]  = dif_q[5];
    opa[6]  = dif_q[2];  opb[6]  = dif_q[9];
    opa[7]  = dif_q[3];  opb[7]  = dif_q[8];
    opa[8]  = dif_q[10]; opb[8]  = dif_q[2];
    opa[9]  = dif_q[11]; opb[9]  = dif_q[0];
    opa[10] = dif_q[10]; opb[10] = crd_q[0];
    opa[11] = dif_q[0];  opb[11] = crd_q[1];
    opa[12] = dif_q[11]; opb[12] = crd_q[2];
    opa[13] = dif_q[2];  opb[13] = crd_q[3];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 14; i++) begin
        prd_q[i] <= PW'(opa[i]) * PW'(opb[i]);
      end
      ab_b_q[0] <= dif_q[10];
      ab_b_q[1] <= dif_q[0];
      ab_b_q[2] <= dif_q[11];
      ab_b_q[3] <= dif_q[2];
      ov_b_q    <= ov_a_q;
    end
  end

  // Stage C: orientation sums, determinant and line constants.
  logic signed [SW-1:0] s_q [4];
  logic signed [SW-1:0] det_c_q, c1_q, c2_q;
  logic signed [DW-1:0] ab_c_q [4];
  logic ov_c_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        s_q[i] <= SW'(prd_q[2*i]) - SW'(prd_q[2*i+1]);
      end
      det_c_q <= SW'(prd_q[8]) - SW'(prd_q[9]);
      c1_q    <= -(SW'(prd_q[10]) + SW'(prd_q[11]));
      c2_q    <= -(SW'(prd_q[12]) + SW'(prd_q[13]));
      ab_c_q  <= ab_b_q;
      ov_c_q  <= ov_b_q;
    end
  end

  // Stage D: numerator products and orientation signs.
  logic signed [NW-1:0] m_q [4];
  logic signed [SW-1:0] det_d_q;
  logic [SW-1:0] mag [4];
  logic pos [4];
  logic ngt [4];
  logic hit_d, hit_d_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag[i] = s_q[i][SW-1] ? SW'(-s_q[i]) : SW'(s_q[i]);
      if ((s_q[i] == '0) || (mag[i] < SW'(cross_tol_i))) begin
        pos[i] = 1'b0;
        ngt[i] = 1'b0;
      end else begin
        pos[i] = !s_q[i][SW-1];
        ngt[i] = s_q[i][SW-1];
      end
    end
    hit_d = ov_c_q &&
            !((pos[0] && pos[1]) || (ngt[0] && ngt[1])) &&
            !((pos[2] && pos[3]) || (ngt[2] && ngt[3]));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0]  <= NW'(ab_c_q[1]) * NW'(c2_q);
      m_q[1]  <= NW'(ab_c_q[3]) * NW'(c1_q);
      m_q[2]  <= NW'(c1_q) * NW'(ab_c_q[2]);
      m_q[3]  <= NW'(c2_q) * NW'(ab_c_q[0]);
      det_d_q <= det_c_q;
      hit_d_q <= hit_d;
    end
  end

  // Stage E: numerators, determinant, parallel flag and hit.
  sit_pkg::geom_out_t out_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q.nx  <= m_q[0] - m_q[1];
      out_q.ny  <= m_q[2] - m_q[3];
      out_q.det <= det_d_q;
      out_q.par <= (det_d_q == '0);
      out_q.hit <= hit_d_q;
    end
  end

  assign out_o = out_q;

endmodule

@@ src/sit_div.sv @@
// Pipelined fixed-point divider lane, two quotient bits per stage.
module sit_div (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [sit_pkg::NW-1:0]     num_i,
  input  logic signed [sit_pkg::SW-1:0]     den_i,
  output sit_pkg::div_res_t                 res_o
);

  localparam int NW = sit_pkg::NW;
  localparam int SW = sit_pkg::SW;
  localparam int DENW = sit_pkg::DENW;
  localparam int QW = sit_pkg::QW;
  localparam int HIW = sit_pkg::HIW;
  localparam int FRAC = sit_pkg::FRAC;
  localparam int STG = sit_pkg::DIV_STG;

  // Magnitudes and result sign.
  logic [NW-1:0]   nmag_q;
  logic [DENW-1:0] dmag_p_q;
  logic            neg_p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nmag_q   <= num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
      dmag_p_q <= den_i[SW-1] ? DENW'(-den_i) : DENW'(den_i);
      neg_p_q  <= num_i[NW-1] ^ den_i[SW-1];
    end
  end

  // Overflow check on the upper dividend part.
  logic [NW+FRAC-1:0] shd;
  logic [HIW-1:0]     hi;
  logic               ovf_c;

  logic [DENW-1:0] rem_q  [STG+1];
  logic [QW-1:0]   dq_q   [STG+1];
  logic [DENW-1:0] dmag_q [STG+1];
  logic            neg_q  [STG+1];
  logic            ovf_q  [STG+1];

  always_comb begin
    shd   = {nmag_q, FRAC'(0)};
    hi    = shd[NW+FRAC-1:QW];
    ovf_c = (hi >= HIW'(dmag_p_q));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= ovf_c ? '0 : hi[DENW-1:0];
      dq_q[0]   <= shd[QW-1:0];
      dmag_q[0] <= dmag_p_q;
      neg_q[0]  <= neg_p_q;
      ovf_q[0]  <= ovf_c;
    end
  end

  for (genvar g = 0; g < STG; g++) begin : g_stg
    logic [DENW-1:0] r_c;
    logic [QW-1:0]   q_c;
    logic [DENW:0]   t;

    always_comb begin
      r_c = rem_q[g];
      q_c = dq_q[g];
      t   = '0;
      for (int k = 0; k < sit_pkg::DIV_STEP; k++) begin
        t   = {r_c, q_c[QW-1]};
        q_c = {q_c[QW-2:0], 1'b0};
        if (t >= {1'b0, dmag_q[g]}) begin
          t      = t - {1'b0, dmag_q[g]};
          q_c[0] = 1'b1;
        end
        r_c = t[DENW-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g+1]  <= r_c;
        dq_q[g+1]   <= q_c;
        dmag_q[g+1] <= dmag_q[g];
        neg_q[g+1]  <= neg_q[g];
        ovf_q[g+1]  <= ovf_q[g];
      end
    end
  end

  assign res_o.q   = dq_q[STG];
  assign res_o.ovf = ovf_q[STG] | (|rem_q[STG] & 1'b0) | (|dmag_q[STG] & 1'b0);
  assign res_o.neg = neg_q[STG];

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench for the segment intersection test unit with an in-bench predictor.
module tb_top;

  typedef struct {
    logic               hit;
    logic               par;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               sat;
  } isect_t;

  localparam int REG_COORD_TOL = 0;
  localparam int REG_CROSS_TOL = 1;
  localparam int STALL_LIMIT = 20000;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [2:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [127:0]  s_axis_tdata = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [71:0]   m_axis_tdata;

  int unsigned src_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned coord_tol = 0;
  int unsigned cross_tol = 0;
  isect_t      pending_q[$];
  int          mismatches = 0;
  int          idle_cycles = 0;

  segment_intersection_test_unit uut (.*);

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    isect_t e;
    isect_t a;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      a.hit = m_axis_tdata[0];
      a.par = m_axis_tdata[1];
      a.px = m_axis_tdata[33:2];
      a.py = m_axis_tdata[65:34];
      a.sat = m_axis_tdata[66];
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result item %h", m_axis_tdata);
      end else begin
        e = pending_q.pop_front();
        if (e.hit !== a.hit || e.par !== a.par || e.px !== a.px || e.py !== a.py
            || e.sat !== a.sat) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: exp hit=%0b par=%0b x=%0d y=%0d sat=%0b",
                     e.hit, e.par, e.px, e.py, e.sat);
            $display("          got hit=%0b par=%0b x=%0d y=%0d sat=%0b",
                     a.hit, a.par, a.px, a.py, a.sat);
          end
        end
      end
    end
  end

  function automatic bit spans_meet(longint l1, longint r1, longint l2, longint r2);
    longint t;
    if (l1 > r1) begin t = l1; l1 = r1; r1 = t; end
    if (l2 > r2) begin t = l2; l2 = r2; r2 = t; end
    return ((l1 > l2) ? l1 : l2) <= ((r1 < r2) ? r1 : r2) + longint'(coord_tol);
  endfunction

  function automatic int side_of(longint ax, longint ay, longint bx, longint by,
                                 longint cx, longint cy);
    longint s;
    longint m;
    s = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
    m = (s < 0) ? -s : s;
    if (s == 0 || m < longint'(cross_tol)) return 0;
    return (s > 0) ? 1 : -1;
  endfunction

  function automatic logic signed [31:0] q16_quot(logic signed [127:0] num,
                                                  logic signed [127:0] den, ref bit sat);
    logic signed [127:0] q;
    q = (num <<< sit_pkg::FRAC) / den;
    if (q > 128'sd2147483647) begin sat = 1; return 32'h7fffffff; end
    if (q < -128'sd2147483648) begin sat = 1; return 32'h80000000; end
    return q[31:0];
  endfunction

  function automatic isect_t predict_isect(logic [127:0] d);
    longint c[8];
    longint a1, b1, c1, a2, b2, c2, det;
    isect_t r;
    bit sat;
    for (int i = 0; i < 8; i++) c[i] = longint'($signed(d[16*i +: 16]));
    r.hit = spans_meet(c[0], c[2], c[4], c[6]) && spans_meet(c[1], c[3], c[5], c[7])
      && side_of(c[0], c[1], c[2], c[3], c[4], c[5])
         * side_of(c[0], c[1], c[2], c[3], c[6], c[7]) <= 0
      && side_of(c[4], c[5], c[6], c[7], c[0], c[1])
         * side_of(c[4], c[5], c[6], c[7], c[2], c[3]) <= 0;
    a1 = c[1] - c[3];
    b1 = c[2] - c[0];
    c1 = -(a1 * c[0] + b1 * c[1]);
    a2 = c[5] - c[7];
    b2 = c[6] - c[4];
    c2 = -(a2 * c[4] + b2 * c[5]);
    det = a1 * b2 - a2 * b1;
    sat = 0;
    r.par = (det == 0);
    r.px = 0;
    r.py = 0;
    if (det != 0) begin
      r.px = q16_quot(128'(b1) * 128'(c2) - 128'(b2) * 128'(c1), 128'(det), sat);
      r.py = q16_quot(128'(c1) * 128'(a2) - 128'(c2) * 128'(a1), 128'(det), sat);
    end
    r.sat = sat;
    return r;
  endfunction

  task automatic send_pair(logic [127:0] d);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    pending_q.push_back(predict_isect(d));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_coords(int v0, int v1, int v2, int v3, int v4, int v5, int v6, int v7);
    send_pair({16'(v7), 16'(v6), 16'(v5), 16'(v4), 16'(v3), 16'(v2), 16'(v1), 16'(v0)});
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (sit_pkg::LAT + 10) @(posedge clk_i);
  endtask

  task automatic write_reg(int idx, logic [31:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 3'(4 * idx);
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_COORD_TOL) coord_tol = v[7:0];
    else if (idx == REG_CROSS_TOL) cross_tol = v[15:0];
    @(posedge clk_i);
  endtask

  task automatic set_tolerances(int ct, int xt);
    drain_results();
    write_reg(REG_COORD_TOL, ct);
    write_reg(REG_CROSS_TOL, xt);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(3))
      0: return 16'($urandom_range(32) - 16);
      1: return 16'($urandom_range(400) - 200);
      2: return $urandom_range(1) ? 16'h7fff - 16'($urandom_range(3))
                                  : 16'h8000 + 16'($urandom_range(3));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    send_coords(0, 0, 10, 10, 0, 10, 10, 0);
    send_coords(0, 0, 10, 0, 0, 5, 10, 5);
    send_coords(0, 0, 10, 0, 5, 0, 20, 0);
    send_coords(0, 0, 4, 4, 4, 4, 8, 0);
    send_coords(0, 0, 1, 0, 3, -1, 3, 1);
    send_coords(0, 0, 0, 0, 0, 0, 0, 0);
    send_coords(0, 0, 3, 1, 0, 1, 1, 0);
    send_coords(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    send_coords(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768);
    send_coords(-32768, 0, 32767, 1, -32768, 1, 32767, 0);
    send_coords(-32768, -32768, 32767, -32767, 32767, 32767, -32768, 32766);
    send_coords(0, 0, 1, 1, -32768, 32767, -32767, 32767);
    send_coords(-1, -1, -1, -1, -1, -1, -1, -1);
    send_coords(0, 0, 2, 0, 3, 1, 3, 2);
  endtask

  task automatic test_tolerances();
    set_tolerances(255, 65535);
    send_coords(0, 0, 10, 0, 12, 3, 12, 8);
    send_coords(0, 0, 100, 1, 0, 2, 100, 3);
    send_coords(-32768, -32768, 32767, 32767, 300, -32768, 32767, -100);
    set_tolerances(3, 5);
    send_coords(0, 0, 10, 0, 12, 1, 12, 8);
    send_coords(0, 0, 10, 1, 0, 2, 5, 3);
  endtask

  task automatic test_random(int n);
    int unsigned phase;
    logic [127:0] d;
    for (int i = 0; i < n; i++) begin
      if (i % 80 == 79) begin
        phase = $urandom_range(2);
        set_tolerances(phase == 0 ? 0 : (phase == 1 ? 255 : $urandom_range(255)),
                       phase == 0 ? 0 : (phase == 1 ? 65535 : $urandom_range(300)));
      end
      for (int k = 0; k < 8; k++) d[16*k +: 16] = rand_coord();
      if ($urandom_range(9) == 0) d[127:64] = {d[47:32], d[63:48], d[15:0], d[31:16]};
      send_pair(d);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    src_idle_pct = 6;
    sink_idle_pct = 72;
    test_directed();
    test_tolerances();
    set_tolerances(0, 0);
    test_random(240);
    src_idle_pct = 72;
    sink_idle_pct = 6;
    test_random(230);
    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_random(230);
    drain_results();
    if (mismatches == 0 && pending_q.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
